// ===== src/rrt_pkg.sv =====
// shared codes and types for the round-robin turn ring
`timescale 1ns / 1ps
package rrt_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_NEXT   = 2'd2;
  localparam kind_t KIND_SKIP   = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage

// ===== src/round_robin_turn_ring_unit.sv =====
// top level: turn ring controller around the member id memory
`timescale 1ns / 1ps
// Round-robin turn ring. Members are kept in ring order in a single
// MAX_PLAYERS-deep id memory (one write port, one registered read port),
// with the member count and the current-turn index in flip-flops. A word is
// taken when start is high and busy is low; exactly one result word follows,
// shown for one cycle with out_valid, and the receiver cannot stall it.
// Remove runs the search and the gap close as one pass over the memory
// read port, one entry read per cycle, each entry after the match written
// back one place down as its read data returns. busy drops in the cycle
// that shows out_valid, so a new word may be started there.
module round_robin_turn_ring_unit import rrt_pkg::*; #(
  parameter int MAX_PLAYERS = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_kind,
  input  logic [ID_BITS-1:0]                 in_member_id,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [ID_BITS-1:0]                 out_turn_id,
  output logic [ID_BITS-1:0]                 out_skipped_id,
  output logic [$clog2(MAX_PLAYERS+1)-1:0]   out_member_count,
  output logic                               out_winner_valid,
  output logic [ID_BITS-1:0]                 out_winner_id
);

  localparam int IDX_W = $clog2(MAX_PLAYERS);
  localparam int CNT_W = $clog2(MAX_PLAYERS + 1);

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // remove: search and compact
  localparam logic [2:0] S_RD   = 3'd2;  // next/skip: read current member
  localparam logic [2:0] S_CAP  = 3'd3;  // next/skip: take read data, advance
  localparam logic [2:0] S_FIN  = 3'd4;  // read head for the winner field
  localparam logic [2:0] S_OUT  = 3'd5;  // load the result word

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   turn_r, turn_nxt;

  // working registers of the word in flight
  kind_t              kind_r, kind_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  status_t            status_r, status_nxt;
  logic [ID_BITS-1:0] turn_id_r, turn_id_nxt;
  logic [ID_BITS-1:0] skip_id_r, skip_id_nxt;
  logic               phase_r, phase_nxt;

  // remove scan
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;

  // result word
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ID_BITS-1:0] out_turn_r, out_turn_nxt;
  logic [ID_BITS-1:0] out_skip_r, out_skip_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic               out_win_r, out_win_nxt;
  logic [ID_BITS-1:0] out_win_id_r, out_win_id_nxt;

  // memory port
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;

  // scan helpers
  logic               scan_issue;
  logic               scan_hit;
  logic               scan_last;
  logic [IDX_W-1:0]   turn_dec;
  logic [IDX_W-1:0]   turn_adv;
  logic [CNT_W-1:0]   turn_inc;

  rrt_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MAX_PLAYERS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // wrap-around advance of the turn pointer
  assign turn_inc = CNT_W'(turn_r) + CNT_W'(1);
  assign turn_adv = (turn_inc >= count_r) ? '0 : turn_inc[IDX_W-1:0];

  assign scan_issue = (scan_r < count_r);
  assign scan_hit   = rd_vld_r && !found_r && (mem_rdata == id_r);
  assign scan_last  = rd_vld_r && (CNT_W'(rd_idx_r) == count_r - CNT_W'(1));
  // turn index after removing entry k_nxt
  assign turn_dec   = (turn_r > k_nxt) ? turn_r - IDX_W'(1) : turn_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    turn_nxt       = turn_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    status_nxt     = status_r;
    turn_id_nxt    = turn_id_r;
    skip_id_nxt    = skip_id_r;
    phase_nxt      = phase_r;
    scan_nxt       = scan_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    k_nxt          = k_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_turn_nxt   = out_turn_r;
    out_skip_nxt   = out_skip_r;
    out_count_nxt  = out_count_r;
    out_win_nxt    = out_win_r;
    out_win_id_nxt = out_win_id_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IDX_W-1:0];
    mem_wdata      = in_member_id;
    mem_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt    = kind_t'(in_kind);
          id_nxt      = in_member_id;
          status_nxt  = ST_OK;
          turn_id_nxt = '0;
          skip_id_nxt = '0;
          phase_nxt   = 1'b0;
          scan_nxt    = '0;
          found_nxt   = 1'b0;
          if (CNT_W'(turn_r) >= count_r) begin
            turn_nxt = '0;
          end
          if (kind_t'(in_kind) == KIND_ADD) begin
            if (count_r >= CNT_W'(MAX_PLAYERS)) begin
              status_nxt = ST_FULL;
            end else begin
              // append at the tail
              mem_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              if (count_r == '0) begin
                turn_nxt = '0;
              end
            end
            state_nxt = S_FIN;
          end else if (count_r == '0) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_FIN;
          end else if (kind_t'(in_kind) == KIND_REMOVE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle, handle the data of the previous one
        mem_raddr = scan_r[IDX_W-1:0];
        if (scan_issue) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt   = scan_r + CNT_W'(1);
        end
        if (rd_vld_r && found_r) begin
          // shift entries after the match down by one
          mem_we    = 1'b1;
          mem_waddr = rd_idx_r - IDX_W'(1);
          mem_wdata = mem_rdata;
        end
        if (scan_hit) begin
          found_nxt = 1'b1;
          k_nxt     = rd_idx_r;
        end
        if (scan_last) begin
          rd_vld_nxt = 1'b0;
          if (!found_nxt) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            turn_nxt  = (CNT_W'(turn_dec) >= count_r - CNT_W'(1)) ? '0 : turn_dec;
          end
          state_nxt = S_FIN;
        end
      end

      S_RD: begin
        mem_raddr = turn_r;
        state_nxt = S_CAP;
      end

      S_CAP: begin
        turn_nxt = turn_adv;
        if (kind_r == KIND_SKIP && !phase_r) begin
          skip_id_nxt = mem_rdata;
          phase_nxt   = 1'b1;
          state_nxt   = S_RD;
        end else begin
          turn_id_nxt = mem_rdata;
          state_nxt   = S_FIN;
        end
      end

      S_FIN: begin
        mem_raddr = '0;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_turn_nxt   = turn_id_r;
        out_skip_nxt   = skip_id_r;
        out_count_nxt  = count_r;
        out_win_nxt    = (count_r == CNT_W'(1));
        out_win_id_nxt = (count_r == CNT_W'(1)) ? mem_rdata : '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      turn_r      <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      turn_r      <= turn_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    status_r     <= status_nxt;
    turn_id_r    <= turn_id_nxt;
    skip_id_r    <= skip_id_nxt;
    scan_r       <= scan_nxt;
    rd_idx_r     <= rd_idx_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_turn_r   <= out_turn_nxt;
    out_skip_r   <= out_skip_nxt;
    out_count_r  <= out_count_nxt;
    out_win_r    <= out_win_nxt;
    out_win_id_r <= out_win_id_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_turn_id      = out_turn_r;
  assign out_skipped_id   = out_skip_r;
  assign out_member_count = out_count_r;
  assign out_winner_valid = out_win_r;
  assign out_winner_id    = out_win_id_r;

endmodule

// ===== src/rrt_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module rrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rrt_chk.sv =====
// port-level checker for the turn ring, bound to the top level
`timescale 1ns / 1ps
module rrt_chk import rrt_pkg::*; #(
  parameter int ID_BITS = 16,
  parameter int CNT_W   = 5
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [1:0]         out_status,
  input logic [ID_BITS-1:0] out_turn_id,
  input logic [ID_BITS-1:0] out_skipped_id,
  input logic [CNT_W-1:0]   out_member_count,
  input logic               out_winner_valid,
  input logic [ID_BITS-1:0] out_winner_id
);

  // a word taken makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // winner flag follows the member count
  a_winner_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_winner_valid == (out_member_count == CNT_W'(1))))
    else $error("winner flag does not match member count");

  // no winner id without a winner
  a_winner_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_winner_valid |-> out_winner_id == '0)
    else $error("winner id set without winner");

  // refused words carry no turn ids
  a_err_ids: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_turn_id == '0 && out_skipped_id == '0)
    else $error("turn ids on an error result");

endmodule

bind round_robin_turn_ring_unit rrt_chk #(
  .ID_BITS (ID_BITS),
  .CNT_W   (CNT_W)
) u_rrt_chk (.*);

// ===== verif/tb_round_robin_turn_ring_unit.sv =====
// testbench for the round-robin turn ring: directed and random words checked against a predictor
`timescale 1ns / 1ps
module tb_round_robin_turn_ring_unit;
  import rrt_pkg::*;

  localparam int MAX_PLAYERS = 16;
  localparam int ID_BITS     = 16;
  localparam int CNT_BITS    = $clog2(MAX_PLAYERS + 1);
  localparam int CLK_PERIOD  = 12;
  // longest correct wait between accepts is a full-ring remove plus a sender gap
  localparam int STALL_LIMIT = 2000;
  // tail after the last expected word: longer than the slowest remove
  localparam int DRAIN_CYCLES = MAX_PLAYERS + 24;

  typedef logic [ID_BITS-1:0] member_id_t;

  typedef struct packed {
    status_t             status;
    member_id_t          turn_id;
    member_id_t          skipped_id;
    logic [CNT_BITS-1:0] member_count;
    logic                winner_valid;
    member_id_t          winner_id;
  } turn_result_t;

  // ids that repeat often, so removes hit and duplicates show up
  localparam member_id_t ID_POOL [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                         16'h5AA5, 16'hA55A, 16'h00FF, 16'h1234};

  // predictor of the ring plus the queue of result words still owed by the block
  class turn_scoreboard;
    member_id_t   ring [MAX_PLAYERS];
    int unsigned  ring_len;
    int unsigned  turn_pos;
    turn_result_t owed [$];
    int unsigned  mismatches;

    function new();
      ring_len   = 0;
      turn_pos   = 0;
      mismatches = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function int unsigned step_on(int unsigned pos);
      return (pos + 1 >= ring_len) ? 0 : pos + 1;
    endfunction

    // work out the result word owed for one accepted input word
    function void note_word(kind_t kind, member_id_t id);
      turn_result_t res;
      int unsigned  hit;
      int unsigned  i;
      res = '0;
      res.status = ST_OK;
      if (turn_pos >= ring_len) turn_pos = 0;
      if (kind == KIND_ADD) begin
        if (ring_len >= MAX_PLAYERS) begin
          res.status = ST_FULL;
        end else begin
          if (ring_len == 0) turn_pos = 0;
          ring[ring_len] = id;
          ring_len++;
        end
      end else if (ring_len == 0) begin
        res.status = ST_EMPTY;
      end else if (kind == KIND_REMOVE) begin
        hit = ring_len;
        for (i = 0; i < ring_len; i++) begin
          if (hit == ring_len && ring[i] == id) hit = i;
        end
        if (hit == ring_len) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < ring_len; i++) ring[i] = ring[i + 1];
          ring_len--;
          if (turn_pos > hit) turn_pos--;
          if (turn_pos >= ring_len) turn_pos = 0;
        end
      end else if (kind == KIND_NEXT) begin
        res.turn_id = ring[turn_pos];
        turn_pos = step_on(turn_pos);
      end else begin
        res.skipped_id = ring[turn_pos];
        turn_pos = step_on(turn_pos);
        res.turn_id = ring[turn_pos];
        turn_pos = step_on(turn_pos);
      end
      res.member_count = CNT_BITS'(ring_len);
      if (ring_len == 1) begin
        res.winner_valid = 1'b1;
        res.winner_id    = ring[0];
      end
      owed.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    // compare one result word with the oldest one owed
    task check_result(turn_result_t got);
      turn_result_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result word with none owed (status %0d)", got.status));
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.turn_id !== want.turn_id)
        report_mismatch($sformatf("turn_id got %h want %h", got.turn_id, want.turn_id));
      if (got.skipped_id !== want.skipped_id)
        report_mismatch($sformatf("skipped_id got %h want %h",
                                  got.skipped_id, want.skipped_id));
      if (got.member_count !== want.member_count)
        report_mismatch($sformatf("member_count got %0d want %0d",
                                  got.member_count, want.member_count));
      if (got.winner_valid !== want.winner_valid)
        report_mismatch($sformatf("winner_valid got %b want %b",
                                  got.winner_valid, want.winner_valid));
      if (got.winner_id !== want.winner_id)
        report_mismatch($sformatf("winner_id got %h want %h", got.winner_id, want.winner_id));
    endtask
  endclass

  // block ports, every input known from time zero
  logic                clk;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic [1:0]          in_kind      = KIND_NEXT;
  member_id_t          in_member_id = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  member_id_t          out_turn_id;
  member_id_t          out_skipped_id;
  logic [CNT_BITS-1:0] out_member_count;
  logic                out_winner_valid;
  member_id_t          out_winner_id;

  turn_scoreboard sb;
  int unsigned    sender_idle_pct = 0;
  int unsigned    quiet_cycles    = 0;

  round_robin_turn_ring_unit #(
    .MAX_PLAYERS(MAX_PLAYERS),
    .ID_BITS    (ID_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_member_id    (in_member_id),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_turn_id     (out_turn_id),
    .out_skipped_id  (out_skipped_id),
    .out_member_count(out_member_count),
    .out_winner_valid(out_winner_valid),
    .out_winner_id   (out_winner_id)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // monitor: values read here are the ones settled before the edge,
  // since every driver and the block update with nonblocking assignments
  always @(posedge clk) begin : monitor
    turn_result_t seen;
    logic         took_word;
    if (rst_n) begin
      took_word = (start === 1'b1) && (busy === 1'b0);
      // result first: a new word can be taken in the cycle that shows the last result
      if (out_valid === 1'b1) begin
        seen.status       = out_status;
        seen.turn_id      = out_turn_id;
        seen.skipped_id   = out_skipped_id;
        seen.member_count = out_member_count;
        seen.winner_valid = out_winner_valid;
        seen.winner_id    = out_winner_id;
        sb.check_result(seen);
      end
      if (took_word) sb.note_word(in_kind, in_member_id);
      // watchdog on cycles where no word moves either way
      if (took_word || out_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // mostly pool ids, a quarter fully random so every id bit toggles
  function automatic member_id_t pick_id();
    if ($urandom_range(3) == 0) return member_id_t'($urandom);
    return ID_POOL[$urandom_range(7)];
  endfunction

  // present one word and hold it until the block takes it;
  // start is never lowered and raised in the same step
  task automatic send_word(kind_t kind, member_id_t id);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_kind      <= kind;
    in_member_id <= id;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // directed words: empty ring, one member, duplicates, full ring, id extremes
  task automatic run_directed();
    int unsigned i;
    send_word(KIND_NEXT, '1);       // turn on an empty ring
    send_word(KIND_SKIP, '0);
    send_word(KIND_REMOVE, '1);     // remove from an empty ring
    send_word(KIND_ADD, '0);        // first add sets the turn
    send_word(KIND_SKIP, '1);       // skip with a single member
    send_word(KIND_NEXT, '0);
    send_word(KIND_REMOVE, 16'h1234); // id not in the ring
    send_word(KIND_ADD, '1);
    send_word(KIND_ADD, '1);        // duplicate id
    send_word(KIND_NEXT, '0);       // turn now on the first duplicate
    send_word(KIND_REMOVE, '1);     // removes the current member, nearest the head
    send_word(KIND_REMOVE, '0);
    send_word(KIND_REMOVE, '1);     // ring emptied, turn back to the head
    for (i = 0; i < MAX_PLAYERS; i++) send_word(KIND_ADD, member_id_t'(16'h1111 * i));
    send_word(KIND_ADD, 16'hBEEF);  // refused, ring full
    send_word(KIND_SKIP, '0);
    send_word(KIND_REMOVE, 16'hFFFF); // tail member
  endtask

  // random words steered toward a drifting fill goal so the ring visits
  // empty, full and everything between; some words are plain noise
  task automatic run_phase(int unsigned words, int unsigned idle_pct);
    int unsigned n;
    int unsigned fill_goal;
    int unsigned roll;
    kind_t       kind;
    member_id_t  id;
    sender_idle_pct = idle_pct;
    fill_goal = MAX_PLAYERS / 2;
    for (n = 0; n < words; n++) begin
      if (n % 60 == 0) begin
        roll = $urandom_range(3);
        fill_goal = (roll == 0) ? 0 : (roll == 1) ? MAX_PLAYERS : $urandom_range(MAX_PLAYERS);
      end
      roll = $urandom_range(99);
      if (roll < 15)
        kind = kind_t'($urandom_range(3));
      else if (sb.ring_len < fill_goal)
        kind = (roll < 70) ? KIND_ADD : (roll < 85) ? KIND_NEXT : KIND_SKIP;
      else if (sb.ring_len > fill_goal)
        kind = (roll < 70) ? KIND_REMOVE : (roll < 85) ? KIND_NEXT : KIND_SKIP;
      else
        kind = (roll < 57) ? KIND_NEXT : (roll < 85) ? KIND_SKIP :
               (roll < 92) ? KIND_ADD : KIND_REMOVE;
      // removes mostly name a member that is present
      if (kind == KIND_REMOVE && sb.ring_len != 0 && $urandom_range(3) != 0)
        id = sb.ring[$urandom_range(sb.ring_len - 1)];
      else
        id = pick_id();
      send_word(kind, id);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // sender idles rarely, then often, then never
    sender_idle_pct = 9;
    run_directed();
    run_phase(440, 9);
    run_phase(465, 53);
    run_phase(465, 0);
    start <= 1'b0;
    // wait for the owed words, then a tail to catch stray results
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.report_mismatch($sformatf("%0d result words never arrived", sb.owed.size()));
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
